[sv/lcc_pkg.sv]
`timescale 1ns / 1ps
package lcc_pkg;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned Q_BITS     = 18;
  localparam int unsigned IN_W       = 288;
  localparam int unsigned OUT_W      = 104;

  localparam logic [17:0] T_ONE  = 18'd65536;
  localparam logic [17:0] T_OVER = 18'd65537;

  typedef struct packed {
    logic [47:0] rem;
    logic [31:0] dmag;
    logic [17:0] q;
    logic        ovf;
    logic        tneg;
    logic        dneg;
    logic        dzero;
    logic        npos;
  } lane_t;

  typedef struct packed {
    logic [2:0][31:0] p0;
    logic [2:0][32:0] d;
    logic [2:0][15:0] c0;
    logic [2:0][16:0] dc;
  } seg_t;

  typedef struct packed {
    logic            vld;
    seg_t            seg;
    lane_t [5:0]     lane;
  } div_stage_t;

  typedef struct packed {
    logic             vld;
    logic             vis;
    logic [2:0][17:0] sp;
    logic [2:0][17:0] ep;
    logic [2:0][15:0] sc;
    logic [2:0][15:0] ec;
  } pts_t;

endpackage

[sv/lcc_setup.sv]
`timescale 1ns / 1ps
module lcc_setup (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [lcc_pkg::IN_W-1:0]     in_data,
  output lcc_pkg::div_stage_t          stage_o
);
  import lcc_pkg::*;

  div_stage_t nxt;
  logic       vld_r;
  div_stage_t data_r;

  always_comb begin
    logic signed [32:0] a, b, dd, num, den;
    logic [32:0]        tmp;
    logic [31:0]        nmag, dmag;
    logic [47:0]        nn;
    logic               nneg, dneg;
    nxt = '0;
    nxt.vld = in_vld;
    for (int i = 0; i < NUM_AXES; i++) begin
      a  = {in_data[32*i+31], in_data[32*i +: 32]};
      b  = {in_data[96+32*i+31], in_data[96+32*i +: 32]};
      dd = b - a;
      nxt.seg.p0[i] = in_data[32*i +: 32];
      nxt.seg.d[i]  = dd;
      nxt.seg.c0[i] = in_data[192+16*i +: 16];
      nxt.seg.dc[i] = {1'b0, in_data[240+16*i +: 16]} - {1'b0, in_data[192+16*i +: 16]};
      for (int h = 0; h < 2; h++) begin
        if (h == 0) begin
          num = -33'sd65536 - a;
          den = dd;
        end else begin
          num = a - 33'sd65536;
          den = -dd;
        end
        nneg = num[32];
        dneg = den[32];
        tmp  = nneg ? (33'd0 - num) : num;
        nmag = tmp[31:0];
        tmp  = dneg ? (33'd0 - den) : den;
        dmag = tmp[31:0];
        nn   = {nmag, 16'h0000};
        nxt.lane[2*i+h].rem   = nn;
        nxt.lane[2*i+h].dmag  = dmag;
        nxt.lane[2*i+h].q     = '0;
        nxt.lane[2*i+h].ovf   = ({2'b00, nn} >= {dmag, 18'h00000});
        nxt.lane[2*i+h].tneg  = nneg ^ dneg;
        nxt.lane[2*i+h].dneg  = dneg;
        nxt.lane[2*i+h].dzero = (dmag == 32'd0);
        nxt.lane[2*i+h].npos  = !nneg && (nmag != 32'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= nxt;
    end
  end

  always_comb begin
    stage_o     = data_r;
    stage_o.vld = vld_r;
  end

endmodule

[sv/lcc_div_cell.sv]
`timescale 1ns / 1ps
module lcc_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  lcc_pkg::div_stage_t stage_i,
  output lcc_pkg::div_stage_t stage_o
);
  import lcc_pkg::*;

  div_stage_t nxt;
  logic       vld_r;
  div_stage_t data_r;

  always_comb begin
    logic [49:0] sub;
    nxt = stage_i;
    for (int l = 0; l < NUM_PLANES; l++) begin
      sub = {2'b00, stage_i.lane[l].rem} - ({18'h00000, stage_i.lane[l].dmag} << BIT);
      if (!sub[49]) begin
        nxt.lane[l].rem    = sub[47:0];
        nxt.lane[l].q[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= stage_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= nxt;
    end
  end

  always_comb begin
    stage_o     = data_r;
    stage_o.vld = vld_r;
  end

endmodule

[sv/lcc_interp.sv]
`timescale 1ns / 1ps
module lcc_interp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  lcc_pkg::div_stage_t stage_i,
  output lcc_pkg::pts_t       pts_o
);
  import lcc_pkg::*;

  logic              vis_nxt;
  logic [16:0]       ent_nxt, lv_nxt;

  logic              v1_r, vis1_r;
  logic [16:0]       ent_r, lv_r;
  seg_t              seg1_r;

  logic              v2_r, vis2_r;
  logic signed [50:0] ps_r [NUM_AXES];
  logic signed [50:0] pe_r [NUM_AXES];
  logic signed [34:0] cs_r [NUM_AXES];
  logic signed [34:0] ce_r [NUM_AXES];
  logic [2:0][31:0]  p0_r;
  logic [2:0][15:0]  c0_r;

  pts_t              pts_nxt;
  logic              v3_r;
  pts_t              pts_r;

  // enter / leave resolution over the six planes in order
  always_comb begin
    logic signed [17:0] t, ent, lv;
    lane_t              ln;
    ent     = '0;
    lv      = $signed(T_ONE);
    vis_nxt = 1'b1;
    for (int l = 0; l < NUM_PLANES; l++) begin
      ln = stage_i.lane[l];
      if (ln.tneg) begin
        t = (ln.q == '0 && !ln.ovf) ? 18'sd0 : -18'sd1;
      end else begin
        t = (ln.ovf || ln.q > T_OVER) ? $signed(T_OVER) : $signed(ln.q);
      end
      if (ln.dzero) begin
        if (ln.npos) begin
          vis_nxt = 1'b0;
        end
      end else if (!ln.dneg) begin
        if (t > lv) begin
          vis_nxt = 1'b0;
        end else if (t > ent) begin
          ent = t;
        end
      end else begin
        if (t < ent) begin
          vis_nxt = 1'b0;
        end else if (t < lv) begin
          lv = t;
        end
      end
    end
    ent_nxt = ent[16:0];
    lv_nxt  = lv[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= stage_i.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vis1_r <= vis_nxt;
      ent_r  <= ent_nxt;
      lv_r   <= lv_nxt;
      seg1_r <= stage_i.seg;
      vis2_r <= vis1_r;
      p0_r   <= seg1_r.p0;
      c0_r   <= seg1_r.c0;
      for (int i = 0; i < NUM_AXES; i++) begin
        ps_r[i] <= $signed({1'b0, ent_r}) * $signed(seg1_r.d[i]);
        pe_r[i] <= $signed({1'b0, lv_r}) * $signed(seg1_r.d[i]);
        cs_r[i] <= $signed({1'b0, ent_r}) * $signed(seg1_r.dc[i]);
        ce_r[i] <= $signed({1'b0, lv_r}) * $signed(seg1_r.dc[i]);
      end
      pts_r  <= pts_nxt;
    end
  end

  function automatic logic [17:0] lcc_clamp(input logic signed [50:0] v);
    logic [17:0] r;
    if (v > 51'sd65536) begin
      r = T_ONE;
    end else if (v < -51'sd65536) begin
      r = 18'd0 - T_ONE;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  always_comb begin
    logic signed [50:0] base;
    logic signed [34:0] cbase, sc, ec;
    pts_nxt     = '0;
    pts_nxt.vld = v2_r;
    pts_nxt.vis = vis2_r;
    for (int i = 0; i < NUM_AXES; i++) begin
      base  = $signed({{19{p0_r[i][31]}}, p0_r[i]});
      cbase = $signed({19'h00000, c0_r[i]});
      sc    = cbase + (cs_r[i] >>> 16);
      ec    = cbase + (ce_r[i] >>> 16);
      if (vis2_r) begin
        pts_nxt.sp[i] = lcc_clamp(base + (ps_r[i] >>> 16));
        pts_nxt.ep[i] = lcc_clamp(base + (pe_r[i] >>> 16));
        pts_nxt.sc[i] = sc[15:0];
        pts_nxt.ec[i] = ec[15:0];
      end
    end
  end

  always_comb begin
    pts_o     = pts_r;
    pts_o.vld = v3_r;
  end

endmodule

[sv/line_clip_3d_color_top.sv]
`timescale 1ns / 1ps
// 3D line clipper with color interpolation. Each input word is one segment
// (two Q16.16 endpoints with Q8.8 colors); it is clipped against the cube
// [-1, 1]^3 by Liang-Barsky. A visible segment yields two output words, the
// clipped start and then the clipped end with tlast set; an invisible one
// yields a single word with tuser (seen) low, tlast high and zero data.
// The path has one setup stage, an 18-cell chain that produces one quotient
// bit per cell for all six plane divisions, three stages of plane resolution,
// multiply and add, and the output register. A new segment enters every cycle
// while the output side keeps up. A visible segment occupies the output port
// for two words, and the pipeline holds while its first word is out, so
// visible lines enter at a lower rate than rejected ones, which can still
// enter one per cycle.
module line_clip_3d_color_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z,
  // start_red, start_green, start_blue, end_red, end_green, end_blue
  input  logic [lcc_pkg::IN_W-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // point_x, point_y, point_z, point_red, point_green, point_blue, zero pad
  output logic [lcc_pkg::OUT_W-1:0] out_tdata,
  output logic                     out_tlast,
  // seen
  output logic                     out_tuser
);
  import lcc_pkg::*;

  localparam int unsigned NCELL = Q_BITS;

  logic       adv;
  logic       final_take;
  div_stage_t chain [NCELL+1];
  pts_t       pts;

  logic       hold_r, phase_r;
  pts_t       item_r;

  assign final_take = out_tvalid && out_tready && (phase_r || !item_r.vis);
  assign adv        = !hold_r || final_take;
  assign in_tready  = adv;

  lcc_setup u_setup (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_tvalid),
    .in_data (in_tdata),
    .stage_o (chain[0])
  );

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    lcc_div_cell #(
      .BIT (NCELL - 1 - j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .stage_i (chain[j]),
      .stage_o (chain[j+1])
    );
  end

  lcc_interp u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .stage_i (chain[NCELL]),
    .pts_o   (pts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= 1'b0;
      phase_r <= 1'b0;
    end else if (adv) begin
      hold_r  <= pts.vld;
      phase_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= pts;
    end
  end

  assign out_tvalid = hold_r;
  assign out_tuser  = item_r.vis;
  assign out_tlast  = phase_r || !item_r.vis;

  always_comb begin
    out_tdata = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      out_tdata[18*i +: 18]    = phase_r ? item_r.ep[i] : item_r.sp[i];
      out_tdata[54+16*i +: 16] = phase_r ? item_r.ec[i] : item_r.sc[i];
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast && out_tuser)
    else $error("second endpoint missing after first");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata == '0)
    else $error("invisible word malformed");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[17:0]) <= 18'sd65536
                && $signed(out_tdata[17:0]) >= -18'sd65536)
    else $error("x out of cube");

endmodule

[verif/tb_line_clip_3d_color_top.sv]
`timescale 1ns / 1ps
module tb_line_clip_3d_color_top;
  import lcc_pkg::*;

  typedef struct packed {
    logic [31:0] sx, sy, sz, ex, ey, ez;
    logic [15:0] sr, sg, sb, er, eg, eb;
  } seg_in_t;

  typedef struct {
    logic        seen;
    logic        last;
    logic [17:0] px, py, pz;
    logic [15:0] pr, pg, pb;
  } point_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;
  logic         out_tlast;
  logic         out_tuser;

  seg_in_t pending_segs[$];
  point_t  expected_points[$];
  int      fail_count;
  int      cyc;
  bit      stim_done;
  int      hold_left;

  line_clip_3d_color_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [287:0] pack_seg(seg_in_t s);
    return {s.eb, s.eg, s.er, s.sb, s.sg, s.sr, s.ez, s.ey, s.ex, s.sz, s.sy, s.sx};
  endfunction

  function automatic longint floor_div_one(longint v);
    if (v >= 0) return v / 65536;
    return -((-v + 65535) / 65536);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic bit test_plane(longint den, longint num, ref longint tin,
                                    ref longint tout);
    longint t;
    if (den > 0) begin
      t = (num * 65536) / den;
      if (t > tout) return 0;
      if (t > tin) tin = t;
    end else if (den < 0) begin
      t = (num * 65536) / den;
      if (t < tin) return 0;
      if (t < tout) tout = t;
    end else if (num > 0) begin
      return 0;
    end
    return 1;
  endfunction

  task automatic predict_clip(seg_in_t s);
    longint p0[3], dp[3], c0[3], dcol[3];
    longint tin, tout, sv, ev, cs, ce;
    bit vis;
    point_t a, b;
    tin = 0;
    tout = 65536;
    vis = 1;
    p0[0] = longint'($signed(s.sx));
    p0[1] = longint'($signed(s.sy));
    p0[2] = longint'($signed(s.sz));
    dp[0] = longint'($signed(s.ex)) - p0[0];
    dp[1] = longint'($signed(s.ey)) - p0[1];
    dp[2] = longint'($signed(s.ez)) - p0[2];
    c0[0] = s.sr;
    c0[1] = s.sg;
    c0[2] = s.sb;
    dcol[0] = longint'(s.er) - c0[0];
    dcol[1] = longint'(s.eg) - c0[1];
    dcol[2] = longint'(s.eb) - c0[2];
    for (int i = 0; i < 3; i++) begin
      if (vis) vis = test_plane(dp[i], -65536 - p0[i], tin, tout);
      if (vis) vis = test_plane(-dp[i], p0[i] - 65536, tin, tout);
    end
    if (!vis) begin
      a = '{0, 1, 0, 0, 0, 0, 0, 0};
      expected_points = {expected_points, a};
      return;
    end
    a.seen = 1;
    a.last = 0;
    b.seen = 1;
    b.last = 1;
    for (int i = 0; i < 3; i++) begin
      sv = p0[i];
      ev = p0[i] + dp[i];
      cs = c0[i];
      ce = c0[i] + dcol[i];
      if (tout < 65536) begin
        ev = p0[i] + floor_div_one(tout * dp[i]);
        ce = c0[i] + floor_div_one(tout * dcol[i]);
      end
      if (tin > 0) begin
        sv = p0[i] + floor_div_one(tin * dp[i]);
        cs = c0[i] + floor_div_one(tin * dcol[i]);
      end
      sv = clamp_unit(sv);
      ev = clamp_unit(ev);
      case (i)
        0: begin
          a.px = sv[17:0]; b.px = ev[17:0]; a.pr = cs[15:0]; b.pr = ce[15:0];
        end
        1: begin
          a.py = sv[17:0]; b.py = ev[17:0]; a.pg = cs[15:0]; b.pg = ce[15:0];
        end
        default: begin
          a.pz = sv[17:0]; b.pz = ev[17:0]; a.pb = cs[15:0]; b.pb = ce[15:0];
        end
      endcase
    end
    expected_points = {expected_points, a, b};
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      2: return 32'($signed($urandom_range(0, 4)) - 2) <<< 16;
      default: return 32'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic seg_in_t rand_seg();
    seg_in_t s;
    s.sx = rand_coord(); s.sy = rand_coord(); s.sz = rand_coord();
    s.ex = rand_coord(); s.ey = rand_coord(); s.ez = rand_coord();
    if ($urandom_range(0, 7) == 0) s.ex = s.sx;
    if ($urandom_range(0, 7) == 0) s.ez = s.sz;
    s.sr = 16'($urandom()); s.sg = 16'($urandom()); s.sb = 16'($urandom());
    s.er = 16'($urandom()); s.eg = 16'($urandom()); s.eb = 16'($urandom());
    return s;
  endfunction

  function automatic seg_in_t make_seg(int sx, int sy, int sz, int ex, int ey, int ez,
                                       logic [15:0] cs, logic [15:0] ce);
    seg_in_t s;
    s = '{sx, sy, sz, ex, ey, ez, cs, cs, cs, ce, ce, ce};
    return s;
  endfunction

  initial begin
    seg_in_t s;
    // directed: inside, crossing, outside, parallel, extremes
    pending_segs = {pending_segs,
                    make_seg(0, 0, 0, 32768, -32768, 16384, 16'h0000, 16'hffff)};
    pending_segs = {pending_segs,
                    make_seg(-131072, 0, 0, 131072, 0, 0, 16'hffff, 16'h0000)};
    pending_segs = {pending_segs,
                    make_seg(0, -196608, 0, 0, 196608, 0, 16'h1234, 16'h8765)};
    pending_segs = {pending_segs,
                    make_seg(0, 0, -131072, 0, 0, 131072, 16'h0100, 16'h0200)};
    pending_segs = {pending_segs,
                    make_seg(131072, 0, 0, 196608, 0, 0, 16'h0, 16'h0)};
    pending_segs = {pending_segs,
                    make_seg(131072, 0, 0, 131072, 65536, 0, 16'h1, 16'h2)};
    pending_segs = {pending_segs,
                    make_seg(0, 131072, 0, 65536, 131072, 0, 16'h1, 16'h2)};
    pending_segs = {pending_segs,
                    make_seg(0, 0, -131072, 0, 0, -131072, 16'h1, 16'h2)};
    pending_segs = {pending_segs,
                    make_seg(65536, 65536, 65536, -65536, -65536, -65536,
                             16'hffff, 16'h0)};
    pending_segs = {pending_segs,
                    make_seg(0, 0, 0, 0, 0, 0, 16'h5555, 16'haaaa)};
    pending_segs = {pending_segs,
                    make_seg(32'h80000000, 32'h80000000, 32'h80000000,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             16'h0, 16'hffff)};
    pending_segs = {pending_segs,
                    make_seg(32'h7fffffff, 0, 0, 32'h80000000, 0, 0,
                             16'hffff, 16'h0)};
    pending_segs = {pending_segs,
                    make_seg(32'h80000000, 32'h80000000, 0, 32'h80000000,
                             32'h80000000, 0, 16'h0, 16'h0)};
    pending_segs = {pending_segs,
                    make_seg(-196608, 196608, 0, 196608, -196608, 0,
                             16'h00ff, 16'hff00)};
    pending_segs = {pending_segs,
                    make_seg(65537, 0, 0, 65537, 0, 0, 16'h0, 16'h0)};
    pending_segs = {pending_segs,
                    make_seg(-65536, 0, 0, -65536, 0, 0, 16'h1, 16'h1)};
    for (int i = 0; i < 534; i++) begin
      s = rand_seg();
      pending_segs = {pending_segs, s};
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_clip(pending_segs.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_segs.size() > 0 &&
            ((cyc > 200 && cyc < 500) || $urandom_range(0, 99) >= 29)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pack_seg(pending_segs[0]);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (pending_segs.size() == 0)
        stim_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    point_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_points.size() == 0) begin
          $error("unexpected output word");
          fail_count++;
        end else begin
          e = expected_points.pop_front();
          if (out_tuser !== e.seen) begin
            $error("seen exp %0d got %0d", e.seen, out_tuser); fail_count++;
          end
          if (out_tlast !== e.last) begin
            $error("last_point exp %0d got %0d", e.last, out_tlast); fail_count++;
          end
          if (out_tdata[17:0] !== e.px) begin
            $error("point_x exp %h got %h", e.px, out_tdata[17:0]); fail_count++;
          end
          if (out_tdata[35:18] !== e.py) begin
            $error("point_y exp %h got %h", e.py, out_tdata[35:18]); fail_count++;
          end
          if (out_tdata[53:36] !== e.pz) begin
            $error("point_z exp %h got %h", e.pz, out_tdata[53:36]); fail_count++;
          end
          if (out_tdata[69:54] !== e.pr) begin
            $error("point_red exp %h got %h", e.pr, out_tdata[69:54]); fail_count++;
          end
          if (out_tdata[85:70] !== e.pg) begin
            $error("point_green exp %h got %h", e.pg, out_tdata[85:70]); fail_count++;
          end
          if (out_tdata[101:86] !== e.pb) begin
            $error("point_blue exp %h got %h", e.pb, out_tdata[101:86]); fail_count++;
          end
        end
      end
      // long hold-off so the pipeline backs up
      if (cyc == 700) hold_left <= 300;
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (cyc > 200 && cyc < 500) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 29);
      end
    end
  end

  initial begin
    fail_count = 0;
    cyc        = 0;
    stim_done  = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    hold_left  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (expected_points.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_points.size() == 0) begin
      $display("tb_line_clip_3d_color_top: PASS");
    end else begin
      $display("tb_line_clip_3d_color_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_line_clip_3d_color_top: FAIL");
    $finish;
  end

endmodule

[filelist.f]
sv/lcc_pkg.sv
sv/lcc_setup.sv
sv/lcc_div_cell.sv
sv/lcc_interp.sv
sv/line_clip_3d_color_top.sv
verif/tb_line_clip_3d_color_top.sv
